### rtl/mavg_pkg.sv
// Shared types and constants of the moving-average / exponential smoothing filter.
// Used by the top level; no dependencies.

package mavg_pkg;

  // Sample width is fixed by the item format
  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned MAX_WINDOW   = 32;
  localparam int unsigned WEIGHT_W     = 17;
  localparam int unsigned WEIGHT_FRAC  = 16;
  localparam int unsigned FILL_W       = 6;
  // Window sum grows by log2 of the longest window (32 samples)
  localparam int unsigned SUM_W        = SAMPLE_W + 5;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = WEIGHT_W;

  localparam logic [FILL_W-1:0] WIN_SHORT = FILL_W'(16);
  localparam logic [FILL_W-1:0] WIN_LONG  = FILL_W'(32);

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = WEIGHT_W'(65536);
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(32768);

  // Filter mode codes
  localparam logic [1:0] MODE_EMA   = 2'd0;
  localparam logic [1:0] MODE_AVG16 = 2'd1;
  localparam logic [1:0] MODE_AVG32 = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WEIGHT = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       segment_start;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered_out;
    logic                       out_valid;
  } out_item_t;

endpackage

### rtl/moving_average_or_ema_filter.sv
// Top level of the moving-average / exponential smoothing filter.
// Depends on mavg_pkg and mavg_ram (delay line storage).

// Usage
//   Input channel in_valid_i/in_ready_o/in_data_i carries one signed sample and a
//   segment-start flag per item; output channel out_valid_o/out_ready_i/out_data_o
//   returns one result item per input item, in order.
//   Mode 0 gives first-order smoothing, y += alpha*(x-y) with alpha in Q1.16.
//   Modes 1 and 2 give the floored mean of the last 16 or 32 samples of the segment;
//   until the window is full the result is zero with out_valid clear.
//   Configuration is written through cfg_we_i/cfg_addr_i/cfg_wdata_i while idle;
//   a mode write restarts the segment.
// Timing
//   The accepting edge writes the new sample into the delay-line RAM and registers
//   the read of the oldest window sample; when stage 1 advances, the running sum
//   and smoothing value are updated and the output register is loaded. One item
//   per cycle is sustained while the receiver is ready. When the receiver stalls,
//   the output register holds its item, the second stage holds one more, and
//   in_ready_o drops only once both are occupied.
// Reset
//   Asynchronous active-low reset empties the pipeline and clears fill count, sum
//   and smoothing value. The RAM needs no clearing: a window entry is read only
//   after the current segment has written it.

module moving_average_or_ema_filter #(
  parameter int unsigned MaxWindow = mavg_pkg::MAX_WINDOW,
  localparam int unsigned AddrW = $clog2(MaxWindow)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  mavg_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output mavg_pkg::out_item_t               out_data_o,
  input  logic                              cfg_we_i,
  input  logic [mavg_pkg::CFG_IDX_W-1:0]    cfg_addr_i,
  input  logic [mavg_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  localparam int unsigned SW    = mavg_pkg::SAMPLE_W;
  localparam int unsigned SumW  = mavg_pkg::SUM_W;
  localparam int unsigned FW    = mavg_pkg::FILL_W;
  localparam int unsigned WW    = mavg_pkg::WEIGHT_W;
  localparam int unsigned FracW = mavg_pkg::WEIGHT_FRAC;
  localparam int unsigned ProdW = SW + 1 + WW + 1;
  localparam bit          LongOk = (MaxWindow >= 32);

  // Configuration registers
  logic [1:0]    mode_q;
  logic [WW-1:0] weight_q;

  // Stage 0 state
  logic [FW-1:0]    fill_q, fill_d;
  logic [AddrW-1:0] wp_q, wp_d;

  // Stage 1 pipeline register
  logic                       s1_valid_q;
  logic signed [SW-1:0]       s1_x_q;
  logic                       s1_seg_q, s1_first_q, s1_full_q, s1_ok_q;

  // Filter state
  logic signed [SumW-1:0] sum_q, sum_d;
  logic signed [SW-1:0]   y_q, y_d;

  // Output register
  logic                 out_valid_q;
  mavg_pkg::out_item_t  out_data_q, out_data_d;

  logic in_accept, s1_adv, out_free, cfg_mode_wr;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_accept  = in_valid_i && in_ready_o;
  assign cfg_mode_wr = cfg_we_i && (cfg_addr_i == mavg_pkg::CFG_IDX_MODE);

  // ---------------- Stage 0: window bookkeeping and RAM access ----------------
  logic [FW-1:0]    win, fc_base, fc_inc;
  logic             first, full, win_ok;
  logic [AddrW:0]   wp_ext, win_ext, old_ext;
  logic [AddrW-1:0] old_addr;
  logic [SW-1:0]    old_sample;

  always_comb begin
    win     = (mode_q == mavg_pkg::MODE_AVG32 && LongOk) ? mavg_pkg::WIN_LONG
                                                          : mavg_pkg::WIN_SHORT;
    fc_base = in_data_i.segment_start ? '0 : fill_q;
    fc_inc  = fc_base + FW'(1);
    first   = (fc_base == '0);
    full    = (fc_base >= win);
    win_ok  = full || (fc_inc == win);

    wp_ext  = {1'b0, wp_q};
    win_ext = (AddrW+1)'(win);
    if (wp_ext >= win_ext) begin
      old_ext = wp_ext - win_ext;
    end else begin
      old_ext = wp_ext + (AddrW+1)'(MaxWindow) - win_ext;
    end
    old_addr = old_ext[AddrW-1:0];

    wp_d = (wp_q == AddrW'(MaxWindow - 1)) ? '0 : wp_q + AddrW'(1);

    priority if (in_accept) begin
      fill_d = full ? fc_base : fc_inc;
    end else if (cfg_mode_wr) begin
      fill_d = '0;
    end else begin
      fill_d = fill_q;
    end
  end

  mavg_ram #(
    .Width (SW),
    .Depth (MaxWindow)
  ) u_delay_line (
    .clk_i   (clk_i),
    .we_i    (in_accept),
    .waddr_i (wp_q),
    .wdata_i (in_data_i.sample_in),
    .re_i    (in_accept),
    .raddr_i (old_addr),
    .rdata_o (old_sample)
  );

  // ---------------- Stage 1: sum, smoothing and result selection ----------------
  logic signed [SumW-1:0]  sum_base, old_term;
  logic [WW-1:0]           alpha;
  logic signed [SW:0]      diff, step;
  logic signed [ProdW-1:0] prod;
  logic signed [SW:0]      y_sum;
  logic signed [SW-1:0]    mean;

  always_comb begin
    sum_base = s1_seg_q ? '0 : sum_q;
    old_term = s1_full_q ? SumW'($signed(old_sample)) : '0;
    sum_d    = sum_base - old_term + SumW'(s1_x_q);

    // Weights above one act as one
    alpha = (weight_q > mavg_pkg::WEIGHT_ONE) ? mavg_pkg::WEIGHT_ONE : weight_q;
    diff  = (SW+1)'(s1_x_q) - (SW+1)'(y_q);
    prod  = ProdW'(diff) * ProdW'($signed({1'b0, alpha}));
    // Bit-select of the product is the floored shift by the fraction width
    step  = prod[FracW+SW:FracW];
    y_sum = (SW+1)'(y_q) + step;
    if (s1_first_q) begin
      y_d = (alpha == '0) ? '0 : s1_x_q;
    end else begin
      y_d = y_sum[SW-1:0];
    end

    if (mode_q == mavg_pkg::MODE_AVG32 && LongOk) begin
      mean = sum_d[SW+4:5];
    end else begin
      mean = sum_d[SW+3:4];
    end

    out_data_d.filtered_out = '0;
    out_data_d.out_valid    = 1'b0;
    unique case (mode_q)
      mavg_pkg::MODE_EMA: begin
        out_data_d.filtered_out = y_d;
        out_data_d.out_valid    = 1'b1;
      end
      mavg_pkg::MODE_AVG16, mavg_pkg::MODE_AVG32: begin
        if (s1_ok_q) begin
          out_data_d.filtered_out = mean;
          out_data_d.out_valid    = 1'b1;
        end
      end
      default: begin
        // Unused mode: drop the result, state still advances
        out_data_d.filtered_out = '0;
        out_data_d.out_valid    = 1'b0;
      end
    endcase
  end

  // ---------------- Registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= mavg_pkg::MODE_EMA;
      weight_q    <= mavg_pkg::WEIGHT_RESET;
      fill_q      <= '0;
      wp_q        <= '0;
      s1_valid_q  <= 1'b0;
      sum_q       <= '0;
      y_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          mavg_pkg::CFG_IDX_MODE:   mode_q   <= cfg_wdata_i[1:0];
          mavg_pkg::CFG_IDX_WEIGHT: weight_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      fill_q <= fill_d;
      if (in_accept) begin
        wp_q <= wp_d;
      end
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      priority if (s1_adv) begin
        sum_q <= sum_d;
        y_q   <= y_d;
      end else if (cfg_mode_wr) begin
        sum_q <= '0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_x_q     <= in_data_i.sample_in;
      s1_seg_q   <= in_data_i.segment_start;
      s1_first_q <= first;
      s1_full_q  <= full;
      s1_ok_q    <= win_ok;
    end
    if (s1_adv) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // Fill count never passes the active window
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= win)
    else $error("fill count exceeds window length");

  // A result marked not valid carries zero
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_data_q.out_valid |-> out_data_q.filtered_out == '0)
    else $error("invalid result carries non-zero sample");

  // Smoothing mode always yields a valid result
  a_ema_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && mode_q == mavg_pkg::MODE_EMA |=> out_valid_q && out_data_q.out_valid)
    else $error("smoothing result not flagged valid");

  // An empty output register never blocks the input side
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled while output register is empty");
`endif

endmodule

### rtl/mavg_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Read-first: a read and write of the same entry in one cycle returns the old data.

module mavg_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
